>>> src/mpt_pkg.sv
// Package for the station presence table: payload structs, opcodes, queue entry type.
// Used by every module of the block; depends on nothing.
package mpt_pkg;

   localparam int TableEntriesDefault = 128;
   localparam logic [7:0] TtlReset = 8'd60;
   localparam logic [15:0] TicksMax = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_FRAME = 2'd0,
      OP_TICK  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [47:0]       station_addr;
      logic [3:0]        radio_channel;
      logic signed [7:0] signal_strength;
      logic [6:0]        entry_index;
   } req_type;

   typedef struct packed {
      logic              was_known;
      logic [6:0]        slot;
      logic              overwrote;
      logic [7:0]        gone_offline;
      logic              read_valid;
      logic [47:0]       read_addr;
      logic [15:0]       read_online_ticks;
      logic              read_offline;
      logic [7:0]        read_ttl;
      logic [3:0]        read_channel;
      logic signed [7:0] read_rssi;
   } rsp_type;

endpackage

>>> src/mpt_front.sv
// Front end: accepts commands and pushes them into a two-entry queue.
// Depends on mpt_pkg.
module mpt_front
   import mpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    q_valid,
   output req_type q_data,
   input  logic    q_pop
);

   logic [1:0] count_ff, count_in;
   req_type    ent_ff [2];
   logic       rd_ff, rd_in;
   logic       wr_ptr;
   logic       push;

   // The queue is full at two entries; busy holds the requester off.
   // Every accepted command is queued, the unused opcode included.
   assign busy    = count_ff[1];
   assign push    = start && !busy;
   assign q_valid = count_ff != 2'd0;
   assign q_data  = ent_ff[rd_ff];
   assign wr_ptr  = rd_ff ^ count_ff[0];

   // Occupancy and read pointer follow each push and pop transfer.
   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
      rd_in    = rd_ff ^ q_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
      end
      if (push) begin
         ent_ff[wr_ptr] <= req_data;
      end
   end

endmodule

>>> src/mpt_back.sv
// Back end: walks the slot table for frames and ticks, reads one slot for reads.
// Depends on mpt_pkg.
module mpt_back
   import mpt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] ttl_default,
   input  logic       q_valid,
   input  req_type    q_data,
   output logic       q_pop,
   output logic       rsp_strobe,
   output rsp_type    rsp_data
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RD    = 5'b00010,
      ST_CHK   = 5'b00100,
      ST_INS   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // Slot storage: valid bits in flops, the rest in one memory.
   typedef struct packed {
      logic [47:0] addr;
      logic [7:0]  ttl;
      logic [15:0] ticks;
      logic        offline;
      logic [3:0]  chan;
      logic [7:0]  rssi;
   } slot_type;

   slot_type mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   slot_type rd_data_ff;
   logic     rd_vld_ff;

   state_type  state_ff, state_in;
   logic [IW:0] idx_ff, idx_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic        hit_ff, hit_in;
   logic [IW-1:0] hit_slot_ff, hit_slot_in;
   logic [7:0]  exp_ff, exp_in;
   req_type     cmd_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        strobe_ff, strobe_in;

   logic          mem_we;
   logic [IW-1:0] mem_wa;
   slot_type      mem_wd;
   logic [IW-1:0] mem_ra;
   logic [IW-1:0] chk_idx;
   logic          rd_in_range;

   assign chk_idx     = idx_ff[IW-1:0] - IW'(1);
   assign rd_in_range = (32'(cmd_ff.entry_index) < 32'(TABLE_ENTRIES));
   assign rsp_strobe  = strobe_ff;
   assign rsp_data    = rsp_ff;

   // Read address: slot zero ahead of a walk, the requested slot for reads,
   // otherwise the walk index.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         if (q_valid && q_data.opcode == OP_READ) begin
            mem_ra = IW'(q_data.entry_index);
         end else begin
            mem_ra = '0;
         end
      end else begin
         mem_ra = idx_ff[IW-1:0];
      end
   end

   // Sequencer: one slot per cycle, read in one cycle and updated in the next.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      ptr_in      = ptr_ff;
      hit_in      = hit_ff;
      hit_slot_in = hit_slot_ff;
      exp_in      = exp_ff;
      rsp_in      = rsp_ff;
      strobe_in   = 1'b0;
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      mem_wa      = chk_idx;
      mem_wd      = rd_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               hit_in = 1'b0;
               exp_in = '0;
               rsp_in = '0;
               if (q_data.opcode == OP_READ) begin
                  state_in = ST_RD;
               end else if (q_data.opcode == OP_NONE) begin
                  // The unused opcode changes nothing and reports all zero.
                  state_in = ST_DONE;
               end else begin
                  idx_in   = (IW+1)'(1);
                  state_in = ST_CHK;
               end
            end
         end
         ST_RD: begin
            if (rd_in_range && rd_vld_ff) begin
               rsp_in.read_valid        = 1'b1;
               rsp_in.read_addr         = rd_data_ff.addr;
               rsp_in.read_online_ticks = rd_data_ff.ticks;
               rsp_in.read_offline      = rd_data_ff.offline;
               rsp_in.read_ttl          = rd_data_ff.ttl;
               rsp_in.read_channel      = rd_data_ff.chan;
               rsp_in.read_rssi         = rd_data_ff.rssi;
            end
            state_in = ST_DONE;
         end
         ST_CHK: begin
            // rd_data_ff holds slot chk_idx here.
            if (rd_vld_ff) begin
               if (cmd_ff.opcode == OP_FRAME) begin
                  if (rd_data_ff.addr == cmd_ff.station_addr) begin
                     mem_we     = 1'b1;
                     mem_wd.ttl = ttl_default;
                     if (rd_data_ff.offline) begin
                        mem_wd.offline = 1'b0;
                        mem_wd.ticks   = '0;
                     end
                     if (!hit_ff) begin
                        hit_slot_in = chk_idx;
                     end
                     hit_in = 1'b1;
                  end
               end else begin
                  mem_we = 1'b1;
                  if (!rd_data_ff.offline && rd_data_ff.ticks != TicksMax) begin
                     mem_wd.ticks = rd_data_ff.ticks + 16'd1;
                  end
                  if (rd_data_ff.ttl <= 8'd1) begin
                     mem_wd.offline = 1'b1;
                     mem_wd.ttl     = ttl_default;
                     if (exp_ff != 8'hFF) begin
                        exp_in = exp_ff + 8'd1;
                     end
                  end else begin
                     mem_wd.ttl = rd_data_ff.ttl - 8'd1;
                  end
               end
            end
            if (idx_ff == (IW+1)'(TABLE_ENTRIES)) begin
               if (cmd_ff.opcode == OP_FRAME) begin
                  state_in = ST_INS;
               end else begin
                  rsp_in.gone_offline = exp_in;
                  state_in = ST_DONE;
               end
            end else begin
               idx_in = idx_ff + (IW+1)'(1);
            end
         end
         ST_INS: begin
            if (hit_ff) begin
               rsp_in.was_known = 1'b1;
               rsp_in.slot      = 7'(hit_slot_ff);
            end else begin
               mem_we          = 1'b1;
               mem_wa          = ptr_ff;
               mem_wd.addr     = cmd_ff.station_addr;
               mem_wd.ttl      = ttl_default;
               mem_wd.ticks    = '0;
               mem_wd.offline  = 1'b0;
               mem_wd.chan     = cmd_ff.radio_channel;
               mem_wd.rssi     = cmd_ff.signal_strength;
               rsp_in.slot     = 7'(ptr_ff);
               rsp_in.overwrote = valid_ff[ptr_ff];
               ptr_in = (ptr_ff == IW'(TABLE_ENTRIES - 1)) ? '0 : ptr_ff + IW'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         ptr_ff    <= '0;
         strobe_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         strobe_ff <= strobe_in;
         rd_vld_ff <= valid_ff[mem_ra];
         if (state_ff == ST_INS && !hit_ff) begin
            valid_ff[ptr_ff] <= 1'b1;
         end
      end
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      hit_slot_ff <= hit_slot_in;
      exp_ff      <= exp_in;
      rsp_ff      <= rsp_in;
      if (q_pop) begin
         cmd_ff <= q_data;
      end
   end

endmodule

>>> src/mac_presence_table_with_aging_unit.sv
// Top level of the station presence table with aging.
// Depends on mpt_pkg, mpt_front and mpt_back.
//
// Usage: a command is transferred when start is high and busy is low. Frame
// commands look up and insert addresses, tick commands age every slot, read
// commands report one slot. Each command yields one result, shown for one
// cycle with rsp_strobe high; the receiver cannot stall it.
// Frames and ticks walk the slot memory one slot per cycle, and a frame then
// takes a final step that inserts the address or reports the hit; a read reads
// only the requested slot. The back end handles one command at a time.
// A two-entry queue lets the front take commands while the back walks.
// An unused opcode changes nothing and yields an all-zero result.
// The configuration register ttl_default is written with csr_we/csr_wdata.
// Reset clears the valid bits, the insert pointer and sets ttl_default to 60;
// there is no clearing pass.
module mac_presence_table_with_aging_unit
   import mpt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntriesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   logic [7:0] ttl_ff;
   logic       q_valid, q_pop;
   req_type    q_data;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TtlReset;
      end else if (csr_we) begin
         ttl_ff <= csr_wdata;
      end
   end

   mpt_front u_front (
      .clock, .reset, .start, .req_data, .busy,
      .q_valid, .q_data, .q_pop
   );

   mpt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock, .reset, .ttl_default(ttl_ff),
      .q_valid, .q_data, .q_pop, .rsp_strobe, .rsp_data
   );

   // A frame result never reports both a hit and an overwrite.
   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.was_known && rsp_data.overwrote))
      else $error("hit and overwrite together");

   // No result strobe is followed directly by another.
   a_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back strobes");

   // The queue is popped only when it holds an entry.
   a_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

endmodule
